// ----- design/ip_port_flow_table_macros.svh -----
// ----------------------------------------------------------------------------
// ip_port_flow_table_macros.svh
// Assertion macros for the flow table checker.
// ----------------------------------------------------------------------------
`ifndef IP_PORT_FLOW_TABLE_MACROS_SVH
`define IP_PORT_FLOW_TABLE_MACROS_SVH

// same-cycle implication, disabled in reset
`define FT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("flow table assertion failed");

// next-cycle implication, disabled in reset
`define FT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("flow table assertion failed");

`endif

// ----- design/ipft_pkg.sv -----
// ----------------------------------------------------------------------------
// ipft_pkg
// Types and constants of the IP/port flow table.
// ----------------------------------------------------------------------------
package ipft_pkg;

    localparam int ENTRIES_DEF = 256;
    localparam int IP_W        = 32;
    localparam int PORT_W      = 16;
    localparam int KEY_W       = IP_W + PORT_W;
    localparam int VAL_W       = 32;
    localparam int STATUS_W    = 2;
    localparam int COUNT_W     = 9;

    typedef enum logic {
        OP_ADD = 1'b0,
        OP_DEL = 1'b1
    } t_opcode;

    // MISS: duplicate on add, absent on delete
    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_CLEAR  = 2'd0,
        S_IDLE   = 2'd1,
        S_SCAN   = 2'd2,
        S_COMMIT = 2'd3
    } t_state;

endpackage

// ----- design/ip_port_flow_table.sv -----
// ----------------------------------------------------------------------------
// ip_port_flow_table
// Exact-match table of (source IP, source port) keys with a 32-bit value each.
// ----------------------------------------------------------------------------
// Usage: a beat is taken when start is high and busy is low. Each request
// gives exactly one result beat, o_strobe high for one cycle, which cannot be
// held off. After reset the block runs a clearing pass over the tag memory
// with busy high. From acceptance to its result beat, a request goes through
// the key search, in which each read is registered and then compared, and a
// write-back: the slot memory has one read port, so the key search reads one
// slot per cycle. A search that finds its key stops early. busy drops in the
// cycle the result beat shows, so the next request can follow right away.
// Slot placement never shows: o_status and o_entry_count depend only on the
// sequence of keys.
// ----------------------------------------------------------------------------
module ip_port_flow_table
    import ipft_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                i_opcode,
    input  logic [IP_W-1:0]     i_source_ip,
    input  logic [PORT_W-1:0]   i_source_port,
    input  logic [VAL_W-1:0]    i_entry_value,
    output logic                o_strobe,
    output logic [STATUS_W-1:0] o_status,
    output logic [COUNT_W-1:0]  o_entry_count
);

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

    // slot memories: tag word is {valid, key}
    logic [KEY_W:0]   r_tag_mem [ENTRIES];
    logic [VAL_W-1:0] r_val_mem [ENTRIES];

    t_state          r_state, n_state;
    logic [IW-1:0]   r_addr;       // clear / read address
    logic            r_issue;      // reads still to issue in this search
    logic [KEY_W:0]  r_rd_tag;     // registered read data
    logic            r_rd_vld;
    logic [IW-1:0]   r_rd_idx;
    t_opcode         r_op;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_val;
    logic            r_hit;
    logic [IW-1:0]   r_hit_idx;
    logic            r_free;
    logic [IW-1:0]   r_free_idx;
    logic [CW-1:0]   r_live;
    logic            r_strobe;
    t_status         r_status;

    // datapath controls
    logic            match;
    logic            tag_we;
    logic [IW-1:0]   tag_waddr;
    logic [KEY_W:0]  tag_wdata;
    logic            val_we;
    t_status         commit_status;
    logic            live_inc;
    logic            live_dec;

    assign match = r_rd_vld && r_rd_tag[KEY_W] && (r_rd_tag[KEY_W-1:0] == r_key);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_addr == LAST) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) n_state = S_SCAN;
            end
            S_SCAN: begin
                // stop on a hit or once the last slot has been compared
                if (match || (r_rd_vld && r_rd_idx == LAST)) n_state = S_COMMIT;
            end
            S_COMMIT: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the state machine
    always_comb begin
        tag_we        = 1'b0;
        tag_waddr     = r_addr;
        tag_wdata     = '0;
        val_we        = 1'b0;
        commit_status = ST_OK;
        live_inc      = 1'b0;
        live_dec      = 1'b0;
        case (r_state)
            S_CLEAR: begin
                tag_we = 1'b1;
            end
            S_COMMIT: begin
                if (r_op == OP_ADD) begin
                    if (r_hit) begin
                        commit_status = ST_MISS;
                    end else if (r_free) begin
                        tag_we    = 1'b1;
                        tag_waddr = r_free_idx;
                        tag_wdata = {1'b1, r_key};
                        val_we    = 1'b1;
                        live_inc  = 1'b1;
                    end else begin
                        commit_status = ST_FULL;
                    end
                end else begin
                    if (r_hit) begin
                        tag_we    = 1'b1;
                        tag_waddr = r_hit_idx;
                        tag_wdata = {1'b0, r_key};
                        live_dec  = 1'b1;
                    end else begin
                        commit_status = ST_MISS;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // slot memories, tag read data registered
    always_ff @(posedge i_clk) begin
        if (tag_we) begin
            r_tag_mem[tag_waddr] <= tag_wdata;
        end
        r_rd_tag <= r_tag_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (val_we) begin
            r_val_mem[r_free_idx] <= r_val;
        end
    end

    // request payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_op  <= t_opcode'(i_opcode);
            r_key <= {i_source_ip, i_source_port};
            r_val <= i_entry_value;
        end
        r_rd_idx <= r_addr;
        if (match) begin
            r_hit_idx <= r_rd_idx;
        end
        if (r_rd_vld && !r_rd_tag[KEY_W] && !r_free) begin
            r_free_idx <= r_rd_idx;
        end
        r_status <= commit_status;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_addr   <= '0;
            r_issue  <= 1'b0;
            r_rd_vld <= 1'b0;
            r_hit    <= 1'b0;
            r_free   <= 1'b0;
            r_live   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == S_COMMIT);
            r_rd_vld <= (r_state == S_SCAN) && r_issue;
            case (r_state)
                S_CLEAR: begin
                    r_addr <= (r_addr == LAST) ? '0 : IW'(r_addr + 1'b1);
                end
                S_IDLE: begin
                    if (start) begin
                        r_addr  <= '0;
                        r_issue <= 1'b1;
                        r_hit   <= 1'b0;
                        r_free  <= 1'b0;
                    end
                end
                S_SCAN: begin
                    if (r_issue) begin
                        if (r_addr == LAST) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_addr <= IW'(r_addr + 1'b1);
                        end
                    end
                    if (match) begin
                        r_hit <= 1'b1;
                    end
                    if (r_rd_vld && !r_rd_tag[KEY_W]) begin
                        r_free <= 1'b1;
                    end
                end
                S_COMMIT: begin
                    r_issue <= 1'b0;
                    if (live_inc) begin
                        r_live <= CW'(r_live + 1'b1);
                    end else if (live_dec) begin
                        r_live <= CW'(r_live - 1'b1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_strobe      = r_strobe;
    assign o_status      = r_status;
    assign o_entry_count = COUNT_W'(r_live);

endmodule

// ----- design/ipft_checker.sv -----
// ----------------------------------------------------------------------------
// ipft_checker
// Port-level checks of the flow table, bound to the top level.
// ----------------------------------------------------------------------------
`include "ip_port_flow_table_macros.svh"

module ipft_checker
    import ipft_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic                o_strobe,
    input logic [STATUS_W-1:0] o_status
);

    // a result beat closes a request that kept the block busy
    `FT_ASSERT_IMP(a_strobe_after_busy, i_clk, i_rst_n, o_strobe, $past(busy))

    // an accepted beat makes the block busy
    `FT_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)

    // result beats are never back to back
    `FT_ASSERT_NXT(a_single_strobe, i_clk, i_rst_n, o_strobe, !o_strobe)

    // only defined status codes
    `FT_ASSERT_IMP(a_status_code, i_clk, i_rst_n, o_strobe,
        o_status == ST_OK || o_status == ST_MISS || o_status == ST_FULL)

endmodule

bind ip_port_flow_table ipft_checker u_ipft_checker (.*);

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the IP/port flow table. Requests are driven on the
// start/busy handshake; a scoreboard class keeps its own key table, predicts
// status and live count for every accepted beat and checks each result beat
// in order. Directed corner cases come first, then random phases that fill
// the table to full, churn it and drain it, under varying sender idle rates.
// ----------------------------------------------------------------------------
module tb_top;
    import ipft_pkg::*;

    localparam int ENTRIES        = ENTRIES_DEF;
    // cycles without any beat in or out before the run is declared hung;
    // the clearing pass and one full search are both well under this
    localparam int WATCHDOG_LIMIT = 4000;
    // quiet time after the last result, longer than one full search
    localparam int DRAIN_CYCLES   = ENTRIES + 40;

    // ------------------------------------------------------------------------
    // Scoreboard: a key -> value map stands in for the slot store. Placement
    // never shows, so only membership and the live count matter.
    // ------------------------------------------------------------------------
    typedef struct {
        t_status            status;
        logic [COUNT_W-1:0] count;
    } t_flow_result;

    class FlowScoreboard;
        logic [VAL_W-1:0] flow_map [bit [KEY_W-1:0]];
        t_flow_result     awaited_q [$];
        int unsigned      capacity;
        int unsigned      mismatches;

        function new(int unsigned cap);
            capacity   = cap;
            mismatches = 0;
        endfunction

        function int unsigned pending();
            return awaited_q.size();
        endfunction

        // one accepted request beat -> one expected result
        function void note_request(t_opcode op, logic [IP_W-1:0] ip,
                                   logic [PORT_W-1:0] port, logic [VAL_W-1:0] val);
            bit [KEY_W-1:0] key;
            t_flow_result   res;
            key = {ip, port};
            if (op == OP_ADD) begin
                // duplicate wins over full: a present key is never re-added
                if (flow_map.exists(key)) begin
                    res.status = ST_MISS;
                end else if (flow_map.num() >= capacity) begin
                    res.status = ST_FULL;
                end else begin
                    flow_map[key] = val;
                    res.status    = ST_OK;
                end
            end else begin
                if (flow_map.exists(key)) begin
                    flow_map.delete(key);
                    res.status = ST_OK;
                end else begin
                    res.status = ST_MISS;
                end
            end
            // the result field carries the low bits of the live count
            res.count = COUNT_W'(flow_map.num());
            awaited_q.push_back(res);
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            mismatches++;
        endtask

        task check_result(logic [STATUS_W-1:0] st, logic [COUNT_W-1:0] cnt);
            t_flow_result exp_res;
            if (awaited_q.size() == 0) begin
                report_mismatch($sformatf("result beat with no request pending (st=%0d cnt=%0d)",
                                          st, cnt));
            end else begin
                exp_res = awaited_q.pop_front();
                if (st !== exp_res.status)
                    report_mismatch($sformatf("status %0d, predicted %0d", st, exp_res.status));
                if (cnt !== exp_res.count)
                    report_mismatch($sformatf("entry_count %0d, predicted %0d",
                                              cnt, exp_res.count));
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // DUT signals, inputs all known from time zero
    // ------------------------------------------------------------------------
    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                start         = 1'b0;
    logic                busy;
    logic                i_opcode      = OP_ADD;
    logic [IP_W-1:0]     i_source_ip   = '0;
    logic [PORT_W-1:0]   i_source_port = '0;
    logic [VAL_W-1:0]    i_entry_value = '0;
    logic                o_strobe;
    logic [STATUS_W-1:0] o_status;
    logic [COUNT_W-1:0]  o_entry_count;

    FlowScoreboard       sb;
    bit [KEY_W-1:0]      sent_keys [$];     // history, source of hits
    int unsigned         idle_pct = 0;      // sender idle chance per cycle
    int unsigned         quiet_cycles = 0;

    ip_port_flow_table #(
        .ENTRIES (ENTRIES)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_opcode      (i_opcode),
        .i_source_ip   (i_source_ip),
        .i_source_port (i_source_port),
        .i_entry_value (i_entry_value),
        .o_strobe      (o_strobe),
        .o_status      (o_status),
        .o_entry_count (o_entry_count)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Monitor: samples pre-edge values, so it never races the driver NBAs.
    // Notes accepted request beats, checks result beats, runs the watchdog.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy)
                sb.note_request(t_opcode'(i_opcode), i_source_ip, i_source_port,
                                i_entry_value);
            if (o_strobe)
                sb.check_result(o_status, o_entry_count);
            if ((start && !busy) || o_strobe)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driver. Called at a rising edge; returns at the edge that took the beat,
    // so a back-to-back request keeps start high with a single NBA.
    // ------------------------------------------------------------------------
    task send_request(t_opcode op, bit [KEY_W-1:0] key, logic [VAL_W-1:0] val);
        sent_keys.push_back(key);
        // sender idle: start low, fields churn as noise
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do begin
                i_opcode      <= 1'($urandom_range(1));
                i_source_ip   <= $urandom;
                i_source_port <= PORT_W'($urandom_range(16'hFFFF));
                i_entry_value <= $urandom;
                @(posedge i_clk);
            end while ($urandom_range(99) < idle_pct);
        end
        start         <= 1'b1;
        i_opcode      <= op;
        i_source_ip   <= key[KEY_W-1:PORT_W];
        i_source_port <= key[PORT_W-1:0];
        i_entry_value <= val;
        do @(posedge i_clk); while (busy);
    endtask

    // fresh random key, a key seen before, or a seen key with one bit flipped
    function bit [KEY_W-1:0] pick_key(int unsigned fresh_pct);
        bit [KEY_W-1:0] key;
        if (sent_keys.size() == 0 || $urandom_range(99) < fresh_pct) begin
            key = {$urandom, 16'($urandom_range(16'hFFFF))};
        end else begin
            key = sent_keys[$urandom_range(sent_keys.size() - 1)];
            if ($urandom_range(9) == 0)
                key[$urandom_range(KEY_W - 1)] ^= 1'b1;
        end
        return key;
    endfunction

    task run_phase(int unsigned items, int unsigned idle, int unsigned add_pct,
                   int unsigned fresh_pct);
        t_opcode op;
        idle_pct = idle;
        repeat (items) begin
            op = ($urandom_range(99) < add_pct) ? OP_ADD : OP_DEL;
            send_request(op, pick_key(fresh_pct), $urandom);
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        sb = new(ENTRIES);
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, both ops, dup add, absent delete,
        // keys differing only in ip or only in port, re-add after delete
        idle_pct = 0;
        send_request(OP_DEL, '0, '0);                             // delete on empty
        send_request(OP_ADD, '0, '0);
        send_request(OP_ADD, '1, '1);
        send_request(OP_ADD, '0, 32'h5A5A_A5A5);                  // dup, value kept
        send_request(OP_ADD, '1, '0);                             // dup
        send_request(OP_ADD, {32'h0000_0000, 16'hFFFF}, 32'h1);   // port only differs
        send_request(OP_ADD, {32'hFFFF_FFFF, 16'h0000}, 32'h2);   // ip only differs
        send_request(OP_ADD, {32'h8000_0000, 16'h8000}, 32'h8000_0000);
        send_request(OP_ADD, {32'h0000_0001, 16'h0001}, 32'h0000_0001);
        send_request(OP_DEL, {32'h0000_0001, 16'h0000}, '1);      // near miss
        send_request(OP_DEL, '0, '1);                             // value ignored
        send_request(OP_DEL, '0, '0);                             // already gone
        send_request(OP_ADD, '0, 32'hDEAD_BEEF);                  // re-add
        send_request(OP_DEL, '1, '0);
        send_request(OP_DEL, {32'h0000_0000, 16'hFFFF}, '0);
        send_request(OP_DEL, {32'hFFFF_FFFF, 16'h0000}, '0);
        send_request(OP_ADD, {32'hC0A8_0001, 16'd80}, 32'h0BAD_F00D);
        send_request(OP_DEL, {32'hC0A8_0001, 16'd81}, '0);        // absent neighbor

        // random: churn, fill past full, drain, mixed tail
        run_phase(250, 0,  60, 30);
        run_phase(300, 77, 88, 90);    // fills the table, then hits full
        run_phase(250, 7,  25, 5);     // mostly deletes of known keys
        run_phase(150, 0,  50, 50);

        // end: stop requesting, wait for every result plus a quiet tail
        start <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
